/* hw/rtl/lwbm_pkg.sv */
// Shared types and verdict codes for the level weight best model filter.
package lwbm_pkg;

  localparam int SumW = 32;
  localparam int VerdictW = 2;

  localparam logic [VerdictW-1:0] VERDICT_JOIN     = 2'd0;
  localparam logic [VerdictW-1:0] VERDICT_REPLACE  = 2'd1;
  localparam logic [VerdictW-1:0] VERDICT_NOT_BEST = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic acc;      // accept a pair: read its level sum, stage it for update
    logic walk_rd;  // read both banks at the walk address
    logic swap;     // the current bank becomes the best bank
    logic clear;    // clear the valid bits of the bank that is current afterwards
  } lwbm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cmp_vld;   // registered walk data is present
    logic cmp_last;  // that data belongs to level zero
    logic lt;        // candidate sum below best sum
    logic gt;        // candidate sum above best sum
  } lwbm_sts_t;

endpackage

/* hw/rtl/lwbm_datapath.sv */
// Datapath: two banks of level sums with valid bits, accumulator and compare.
module lwbm_datapath #(
  parameter int LEVELS = 16,
  parameter int AW = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  lwbm_pkg::lwbm_cmd_t cmd,
  input  logic [AW-1:0]      walk_addr,
  input  logic [3:0]         level,
  input  logic [15:0]        weight,
  output lwbm_pkg::lwbm_sts_t sts
);
  import lwbm_pkg::*;

  logic [SumW-1:0] mem0 [LEVELS];
  logic [SumW-1:0] mem1 [LEVELS];
  logic [LEVELS-1:0] vld0;
  logic [LEVELS-1:0] vld1;
  logic cur_sel;

  logic [AW-1:0]   rd_addr;
  logic [SumW-1:0] rd0;
  logic [SumW-1:0] rd1;
  logic            rv0;
  logic            rv1;
  logic            cmp_vld;
  logic            cmp_last;

  logic            s1_valid;
  logic            s1_inrange;
  logic [AW-1:0]   s1_addr;
  logic [15:0]     s1_weight;
  logic            fwd_hit;
  logic [SumW-1:0] fwd_data;

  logic [SumW-1:0] val0;
  logic [SumW-1:0] val1;
  logic [SumW-1:0] cur_val;
  logic [SumW-1:0] best_val;
  logic [SumW-1:0] base;
  logic [SumW:0]   sum_wide;
  logic [SumW-1:0] sum_sat;
  logic            wr_en;
  logic            in_range;
  logic            clear_bank;

  assign rd_addr  = cmd.walk_rd ? walk_addr : AW'(level);
  assign in_range = int'(level) < LEVELS;

  assign val0     = rv0 ? rd0 : '0;
  assign val1     = rv1 ? rd1 : '0;
  assign cur_val  = cur_sel ? val1 : val0;
  assign best_val = cur_sel ? val0 : val1;

  // A pair that hits the level written in the previous cycle takes the forwarded sum.
  assign base     = fwd_hit ? fwd_data : cur_val;
  assign sum_wide = {1'b0, base} + {{(SumW + 1 - 16){1'b0}}, s1_weight};
  assign sum_sat  = sum_wide[SumW] ? {SumW{1'b1}} : sum_wide[SumW-1:0];
  assign wr_en    = s1_valid && s1_inrange;

  assign clear_bank = cmd.swap ? ~cur_sel : cur_sel;

  assign sts.cmp_vld  = cmp_vld;
  assign sts.cmp_last = cmp_last;
  assign sts.lt       = cur_val < best_val;
  assign sts.gt       = cur_val > best_val;

  always_ff @(posedge clk) begin
    rd0 <= mem0[rd_addr];
    rd1 <= mem1[rd_addr];
    if (wr_en && !cur_sel) begin
      mem0[s1_addr] <= sum_sat;
    end
    if (wr_en && cur_sel) begin
      mem1[s1_addr] <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr   <= AW'(level);
    s1_weight <= weight;
    fwd_data  <= sum_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0       <= '0;
      vld1       <= '0;
      rv0        <= 1'b0;
      rv1        <= 1'b0;
      cur_sel    <= 1'b0;
      s1_valid   <= 1'b0;
      s1_inrange <= 1'b0;
      fwd_hit    <= 1'b0;
      cmp_vld    <= 1'b0;
      cmp_last   <= 1'b0;
    end else begin
      rv0        <= vld0[rd_addr];
      rv1        <= vld1[rd_addr];
      s1_valid   <= cmd.acc;
      s1_inrange <= in_range;
      fwd_hit    <= wr_en && (s1_addr == AW'(level));
      cmp_vld    <= cmd.walk_rd;
      cmp_last   <= cmd.walk_rd && (walk_addr == '0);
      if (cmd.swap) begin
        cur_sel <= ~cur_sel;
      end
      if (cmd.clear && !clear_bank) begin
        vld0 <= '0;
      end
      if (cmd.clear && clear_bank) begin
        vld1 <= '0;
      end
      if (wr_en && !cur_sel) begin
        vld0[s1_addr] <= 1'b1;
      end
      if (wr_en && cur_sel) begin
        vld1[s1_addr] <= 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/lwbm_ctrl.sv */
// Controller: accepts pairs, walks the levels on the final pair when the best set is nonempty and issues the verdict.
module lwbm_ctrl #(
  parameter int LEVELS = 16,
  parameter int AW = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       last,
  input  lwbm_pkg::lwbm_sts_t        sts,
  output lwbm_pkg::lwbm_cmd_t        cmd,
  output logic [AW-1:0]              walk_addr,
  output logic                       busy,
  output logic                       done,
  output logic [lwbm_pkg::VerdictW-1:0] verdict
);
  import lwbm_pkg::*;

  typedef enum logic [2:0] {
    ST_ACC  = 3'b001,
    ST_FIN  = 3'b010,
    ST_WALK = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [AW-1:0]       walk_idx;
  logic                walk_more;
  logic                nonempty;
  logic                decide;
  logic [VerdictW-1:0] verdict_next;

  assign busy      = (state != ST_ACC);
  assign walk_addr = walk_idx;

  always_comb begin
    decide       = 1'b0;
    verdict_next = VERDICT_NOT_BEST;
    case (state)
      ST_FIN: begin
        // With an empty best set the best vector is still all zero.
        if (!nonempty) begin
          decide       = 1'b1;
          verdict_next = VERDICT_JOIN;
        end
      end
      ST_WALK: begin
        if (sts.cmp_vld) begin
          if (sts.lt) begin
            decide       = 1'b1;
            verdict_next = VERDICT_REPLACE;
          end else if (sts.gt) begin
            decide       = 1'b1;
            verdict_next = VERDICT_NOT_BEST;
          end else if (sts.cmp_last) begin
            decide       = 1'b1;
            verdict_next = VERDICT_JOIN;
          end
        end
      end
      default: begin
        decide = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd.acc     = start && (state == ST_ACC);
    cmd.walk_rd = (state == ST_WALK) && walk_more;
    cmd.swap    = decide && ((verdict_next == VERDICT_REPLACE) || !nonempty);
    cmd.clear   = decide;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_ACC: begin
        if (start && last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        state_next = decide ? ST_ACC : ST_WALK;
      end
      ST_WALK: begin
        if (decide) begin
          state_next = ST_ACC;
        end
      end
      default: begin
        state_next = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (decide) begin
      verdict <= verdict_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      walk_idx  <= '0;
      walk_more <= 1'b0;
      nonempty  <= 1'b0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= decide;
      if (decide && (verdict_next != VERDICT_NOT_BEST)) begin
        nonempty <= 1'b1;
      end
      if ((state == ST_FIN) && !decide) begin
        walk_idx  <= AW'(LEVELS - 1);
        walk_more <= 1'b1;
      end else if (cmd.walk_rd) begin
        if (walk_idx == '0) begin
          walk_more <= 1'b0;
        end else begin
          walk_idx <= walk_idx - 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/level_weight_best_model_filter_unit.sv */
// Top level of the level weight best model filter.
//
//   Channel   Handshake            Payload
//   --------  -------------------  ---------------------
//   pair in   start high, busy low level, weight, last
//   verdict   done, one cycle      verdict
//
// A pair without the last mark is accepted without raising busy; pairs may follow back to back.
// A final pair raises busy for the update state (ST_FIN) plus, when the best set is
// nonempty, a walk over the two bank read ports from the top level down that ends
// at the first level whose sums differ or at level zero, then done strobes for one cycle.
// Reset (rst, synchronous) clears all sums through per-entry valid bits at once.
// The receiver cannot stall; a verdict appears exactly once.
module level_weight_best_model_filter_unit #(
  parameter int LEVELS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [3:0]                    level,
  input  logic [15:0]                   weight,
  input  logic                          last,
  output logic                          done,
  output logic [lwbm_pkg::VerdictW-1:0] verdict
);
  import lwbm_pkg::*;

  localparam int AW = $clog2(LEVELS);

  lwbm_cmd_t     cmd;
  lwbm_sts_t     sts;
  logic [AW-1:0] walk_addr;

  lwbm_ctrl #(
    .LEVELS (LEVELS),
    .AW     (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last      (last),
    .sts       (sts),
    .cmd       (cmd),
    .walk_addr (walk_addr),
    .busy      (busy),
    .done      (done),
    .verdict   (verdict)
  );

  lwbm_datapath #(
    .LEVELS (LEVELS),
    .AW     (AW)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .walk_addr (walk_addr),
    .level     (level),
    .weight    (weight),
    .sts       (sts)
  );

endmodule

/* tb/sv/level_weight_best_model_filter_unit_test.sv */
// Testbench for the level weight best model filter: directed pairs and random models checked against a predictor.
`timescale 1ns / 1ps

module level_weight_best_model_filter_unit_test;
  import lwbm_pkg::*;

  localparam int Levels = 16;
  localparam int RandomPairs = 1300;

  typedef enum int {
    MODEL_EQUAL,
    MODEL_BETTER,
    MODEL_WORSE,
    MODEL_NOISE
  } model_kind_t;

  // Tracks the running level sums and the best vector, and queues the verdict
  // that each final pair must produce.
  class verdict_scoreboard_t;
    bit [31:0] model_sum [Levels];
    bit [31:0] best_sum [Levels];
    bit best_set_nonempty;
    logic [VerdictW-1:0] expected_q [$];
    int errors;

    function new();
      foreach (model_sum[i]) begin
        model_sum[i] = '0;
        best_sum[i] = '0;
      end
      best_set_nonempty = 1'b0;
      errors = 0;
    endfunction

    function bit best_is_zero();
      foreach (best_sum[i]) begin
        if (best_sum[i] != 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_pair(bit [3:0] lvl, bit [15:0] w, bit fin);
      bit [32:0] total;
      int cmp;
      logic [VerdictW-1:0] v;
      if (int'(lvl) < Levels) begin
        total = {1'b0, model_sum[lvl]} + 33'(w);
        model_sum[lvl] = total[32] ? 32'hFFFF_FFFF : total[31:0];
      end
      if (!fin) return;
      if (!best_set_nonempty && best_is_zero()) begin
        best_sum = model_sum;
        v = VERDICT_JOIN;
      end else begin
        // The highest level whose sums differ decides; a lower sum wins.
        cmp = 0;
        for (int i = Levels - 1; i >= 0 && cmp == 0; i--) begin
          if (model_sum[i] < best_sum[i]) cmp = -1;
          else if (model_sum[i] > best_sum[i]) cmp = 1;
        end
        if (cmp < 0) begin
          best_sum = model_sum;
          v = VERDICT_REPLACE;
        end else if (cmp == 0) begin
          v = VERDICT_JOIN;
        end else begin
          v = VERDICT_NOT_BEST;
        end
      end
      if (v != VERDICT_NOT_BEST) best_set_nonempty = 1'b1;
      foreach (model_sum[i]) model_sum[i] = '0;
      expected_q = {expected_q, v};
    endfunction

    function void check_verdict(logic [VerdictW-1:0] got);
      logic [VerdictW-1:0] want;
      if (expected_q.size() == 0) begin
        $display("%0t: verdict with none expected, expected none, actual %0d", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        $display("%0t: verdict mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [3:0] level;
  logic [15:0] weight;
  logic last;
  logic done;
  logic [VerdictW-1:0] verdict;

  verdict_scoreboard_t sb = new();
  int burst_left = 0;
  int pairs_sent = 0;

  level_weight_best_model_filter_unit #(
    .LEVELS(Levels)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .level(level),
    .weight(weight),
    .last(last),
    .done(done),
    .verdict(verdict)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #25_000_000;
    $display("FAIL level_weight_best_model_filter_unit");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_verdict(verdict);
  end

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Called in the time step of a rising edge; returns in the step of the
  // edge that accepted the transaction.
  task automatic send_pair(input bit [3:0] l, input bit [15:0] w, input bit fin);
    if (burst_left == 0) begin
      pause($urandom_range(1, 5));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1'b1;
    level <= l;
    weight <= w;
    last <= fin;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_pair(l, w, fin);
    pairs_sent++;
  endtask

  // Builds a model near the current best vector (or plain noise) and sends
  // its pairs in shuffled order.
  task automatic random_model();
    bit [31:0] target [Levels];
    bit [3:0] pl [$];
    bit [15:0] pw [$];
    model_kind_t kind;
    int h;
    int j;
    bit [3:0] tl;
    bit [15:0] tw;
    bit [31:0] rest;
    bit [31:0] chunk;
    bit [31:0] cap;
    case ($urandom_range(0, 9))
      0, 1, 2: kind = MODEL_EQUAL;
      3, 4, 5: kind = MODEL_BETTER;
      6, 7:    kind = MODEL_WORSE;
      default: kind = MODEL_NOISE;
    endcase
    h = -1;
    for (int i = Levels - 1; i >= 0; i--) begin
      if (sb.best_sum[i] != 0 && h < 0) h = i;
    end
    if (kind == MODEL_BETTER && h < 0) kind = MODEL_EQUAL;
    foreach (target[i]) target[i] = sb.best_sum[i];
    if (kind == MODEL_BETTER) begin
      cap = (target[h] < 4) ? target[h] : 4;
      target[h] -= $urandom_range(1, cap);
    end else if (kind == MODEL_WORSE) begin
      h = $urandom_range(0, Levels - 1);
      target[h] += $urandom_range(1, 300);
    end
    // Below the deciding level the sums do not matter, so they are scrambled.
    if (kind == MODEL_BETTER || kind == MODEL_WORSE) begin
      for (int i = 0; i < h; i++) begin
        target[i] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3 * 65535) : 0;
      end
    end
    if (kind == MODEL_NOISE) begin
      repeat ($urandom_range(1, 8)) begin
        pl = {pl, 4'($urandom_range(0, 15))};
        pw = {pw, 16'($urandom)};
      end
    end else begin
      foreach (target[i]) begin
        rest = target[i];
        while (rest != 0) begin
          cap = (rest > 65535) ? 65535 : rest;
          chunk = $urandom_range(0, 1) ? cap : $urandom_range(1, cap);
          pl = {pl, 4'(i)};
          pw = {pw, 16'(chunk)};
          rest -= chunk;
        end
      end
      repeat ($urandom_range(0, 2)) begin
        pl = {pl, 4'($urandom_range(0, 15))};
        pw = {pw, 16'd0};
      end
    end
    if (pl.size() == 0) begin
      pl = {pl, 4'($urandom_range(0, 15))};
      pw = {pw, 16'd0};
    end
    for (int k = pl.size() - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tl = pl[k];
      pl[k] = pl[j];
      pl[j] = tl;
      tw = pw[k];
      pw[k] = pw[j];
      pw[j] = tw;
    end
    foreach (pl[k]) send_pair(pl[k], pw[k], k == pl.size() - 1);
  endtask

  initial begin
    int random_stop;
    rst <= 1'b1;
    start <= 1'b0;
    level <= '0;
    weight <= '0;
    last <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // First model into an empty best set always joins.
    repeat (3) send_pair(4'd15, 16'hFFFF, 1'b0);
    send_pair(4'd15, 16'hFFFF, 1'b1);
    send_pair(4'd15, 16'hFFFF, 1'b0);
    send_pair(4'd0, 16'h0001, 1'b1);
    send_pair(4'd0, 16'h0001, 1'b0);
    send_pair(4'd15, 16'hFFFF, 1'b1);
    send_pair(4'd15, 16'hFFFF, 1'b0);
    send_pair(4'd0, 16'h0002, 1'b1);
    send_pair(4'd14, 16'hFFFF, 1'b0);
    send_pair(4'd15, 16'h0001, 1'b0);
    send_pair(4'd15, 16'hFFFE, 1'b0);
    send_pair(4'd0, 16'h0000, 1'b1);
    send_pair(4'd15, 16'hFFFE, 1'b0);
    send_pair(4'd3, 16'h0000, 1'b0);
    send_pair(4'd0, 16'hFFFF, 1'b1);
    send_pair(4'd7, 16'hAAAA, 1'b0);
    send_pair(4'd8, 16'h5555, 1'b0);
    send_pair(4'd15, 16'hFFFF, 1'b1);

    random_stop = pairs_sent + RandomPairs;
    while (pairs_sent < random_stop) random_model();

    // An all-zero best vector can never be beaten, so it comes last.
    send_pair(4'd5, 16'h0000, 1'b1);
    send_pair(4'd3, 16'h0001, 1'b1);
    send_pair(4'd15, 16'h0000, 1'b0);
    send_pair(4'd0, 16'h0000, 1'b1);

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (Levels + 4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS level_weight_best_model_filter_unit");
    end else begin
      $display("FAIL level_weight_best_model_filter_unit");
    end
    $finish;
  end

endmodule

/* level_weight_best_model_filter_unit.f */
hw/rtl/lwbm_pkg.sv
hw/rtl/lwbm_datapath.sv
hw/rtl/lwbm_ctrl.sv
hw/rtl/level_weight_best_model_filter_unit.sv
tb/sv/level_weight_best_model_filter_unit_test.sv
